[rtl/core/kmsd_pkg.sv]
// Shared types and constants for the key matrix scanner.
`timescale 1ns / 1ps
package kmsd_pkg;

    localparam int ROW_W    = 3;
    localparam int COL_IN_W = 5;
    localparam int CNT_W    = 16;
    localparam int TIME_W   = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CNT_W-1:0] LOCKOUT_RESET = 16'd20;

    // Per-poll control broadcast to every column lane.
    typedef struct packed {
        logic             step;
        logic             tick;
        logic             read;
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] lockout;
    } t_lane_ctl;

    // Events found by one lane in a read poll.
    typedef struct packed {
        logic press;
        logic release_evt;
    } t_lane_evt;

endpackage

[rtl/core/kmsd_lane.sv]
// One column lane: lockout counters and key states for every row of a column.
`timescale 1ns / 1ps
module kmsd_lane #(
    parameter int NUM_ROWS = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kmsd_pkg::t_lane_ctl i_ctl,
    input  logic                i_closed,
    output kmsd_pkg::t_lane_evt o_evt
);
    import kmsd_pkg::*;

    logic [CNT_W-1:0] r_cnt  [NUM_ROWS];
    logic [CNT_W-1:0] n_cnt  [NUM_ROWS];
    logic [NUM_ROWS-1:0] r_down;
    logic [NUM_ROWS-1:0] n_down;
    logic [NUM_ROWS-1:0] hit_press;
    logic [NUM_ROWS-1:0] hit_release;

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            n_cnt[r]       = r_cnt[r];
            n_down[r]      = r_down[r];
            hit_press[r]   = 1'b0;
            hit_release[r] = 1'b0;
            if (i_ctl.tick && r_cnt[r] != '0) begin
                n_cnt[r] = r_cnt[r] - 1'b1;
            end
            if (i_ctl.read && i_ctl.row == ROW_W'(r) && n_cnt[r] == '0
                    && i_closed != r_down[r]) begin
                n_down[r]      = i_closed;
                n_cnt[r]       = i_ctl.lockout;
                hit_press[r]   = i_closed;
                hit_release[r] = ~i_closed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down <= '0;
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_cnt[r] <= '0;
            end
        end else if (i_ctl.step) begin
            r_down <= n_down;
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_cnt[r] <= n_cnt[r];
            end
        end
    end

    assign o_evt.press       = |hit_press;
    assign o_evt.release_evt = |hit_release;

endmodule

[rtl/core/kmsd_merge.sv]
// Merge stage: gathers lane events into masks and holds the result register.
`timescale 1ns / 1ps
module kmsd_merge #(
    parameter int NUM_COLUMNS = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_read,
    input  logic [kmsd_pkg::ROW_W-1:0] i_row_drive,
    input  logic [kmsd_pkg::ROW_W-1:0] i_scanned_row,
    input  kmsd_pkg::t_lane_evt      i_evt [NUM_COLUMNS],
    output logic                     o_ready,
    output logic                     o_valid,
    input  logic                     i_taken,
    output logic [kmsd_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic                     o_tuser
);
    import kmsd_pkg::*;

    logic [COL_IN_W-1:0] press_mask;
    logic [COL_IN_W-1:0] release_mask;
    logic                r_valid;
    logic [OUT_TDATA_W-1:0] r_tdata;
    logic                r_tuser;

    for (genvar c = 0; c < COL_IN_W; c++) begin : g_mask
        if (c < NUM_COLUMNS) begin : g_lane
            assign press_mask[c]   = i_evt[c].press;
            assign release_mask[c] = i_evt[c].release_evt;
        end else begin : g_none
            assign press_mask[c]   = 1'b0;
            assign release_mask[c] = 1'b0;
        end
    end

    assign o_ready = ~r_valid | i_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_tuser <= i_read;
            r_tdata <= {release_mask, press_mask, i_scanned_row, i_row_drive};
        end
    end

    assign o_valid = r_valid;
    assign o_tdata = r_tdata;
    assign o_tuser = r_tuser;

endmodule

[rtl/core/key_matrix_scan_debounce.sv]
// Top level of the key matrix scanner with per-key lockout debounce.
`timescale 1ns / 1ps
// Each transfer on the s_axis channel is one poll: the millisecond tick and
// the sampled column lines. Polls alternate between a select phase, which
// advances the driven row, and a read phase, which compares the columns of
// the current row with the stored key states and reports presses/releases.
// Every poll yields exactly one transfer on m_axis (tuser = read phase).
// One column lane per matrix column holds that column's lockout counters;
// all counters step down in parallel when the tick changes.
// The result is registered and becomes valid in the cycle after the input transfer.
// Throughput: one poll per cycle while m_axis_tready is high, set by the single
// output register; the lanes finish a poll in the cycle it is accepted.
// If the receiver stalls, s_axis_tready drops until the held result is
// taken; nothing is dropped. Reset (synchronous, active low) clears all
// counters and key states, selects the last row, starts in the select phase,
// zeroes the stored tick and loads the lockout register with 20. The user must
// write the lockout register via the cfg channel only while idle; not enforced.
module key_matrix_scan_debounce #(
    parameter int NUM_ROWS    = 5,
    parameter int NUM_COLUMNS = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kmsd_pkg::CNT_W-1:0]           i_cfg_data,    // lockout_ticks
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] time_now, [36:32] column_bits, [39:37] zero
    input  logic [kmsd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [2:0] row_drive, [5:3] scanned_row, [10:6] press_mask, [15:11] release_mask
    output logic [kmsd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] read_done
    output logic                                 m_axis_tuser
);
    import kmsd_pkg::*;

    logic [CNT_W-1:0]  r_lockout;
    logic [TIME_W-1:0] r_prev_time;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic              r_read;
    logic              merge_ready;
    logic              step;
    logic [TIME_W-1:0] time_now;
    logic [COL_IN_W-1:0] column_bits;
    t_lane_ctl         ctl;
    t_lane_evt         evt [NUM_COLUMNS];

    assign time_now    = s_axis_tdata[TIME_W-1:0];
    assign column_bits = s_axis_tdata[TIME_W +: COL_IN_W];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = merge_ready;
    assign step          = s_axis_tvalid & merge_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout <= LOCKOUT_RESET;
        end else if (i_cfg_valid) begin
            r_lockout <= i_cfg_data;
        end
    end

    always_comb begin
        n_row = r_row;
        if (!r_read) begin
            n_row = (r_row >= ROW_W'(NUM_ROWS - 1)) ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_row       <= ROW_W'(NUM_ROWS - 1);
            r_read      <= 1'b0;
        end else if (step) begin
            r_prev_time <= time_now;
            r_row       <= n_row;
            r_read      <= ~r_read;
        end
    end

    assign ctl.step    = step;
    assign ctl.tick    = time_now != r_prev_time;
    assign ctl.read    = r_read;
    assign ctl.row     = r_row;
    assign ctl.lockout = r_lockout;

    for (genvar c = 0; c < NUM_COLUMNS; c++) begin : g_lane
        logic closed;
        if (c < COL_IN_W) begin : g_in
            assign closed = column_bits[c];
        end else begin : g_open
            assign closed = 1'b0;
        end
        kmsd_lane #(
            .NUM_ROWS (NUM_ROWS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_closed (closed),
            .o_evt    (evt[c])
        );
    end

    kmsd_merge #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_read        (r_read),
        .i_row_drive   (n_row),
        .i_scanned_row (r_read ? r_row : '0),
        .i_evt         (evt),
        .o_ready       (merge_ready),
        .o_valid       (m_axis_tvalid),
        .i_taken       (m_axis_tready),
        .o_tdata       (m_axis_tdata),
        .o_tuser       (m_axis_tuser)
    );

endmodule

[verif/tb.sv]
// Self-checking testbench for the key matrix scanner with per-key lockout debounce.
`timescale 1ns / 1ps
module tb;
    import kmsd_pkg::*;

    localparam int NUM_ROWS    = 5;
    localparam int NUM_COLUMNS = 5;
    localparam int NUM_KEYS    = NUM_ROWS * NUM_COLUMNS;
    localparam int STALL_LIMIT = 1000;
    localparam int IDLE_PCT    = 18;

    typedef struct packed {
        logic [ROW_W-1:0]    row_drive;
        logic                read_done;
        logic [ROW_W-1:0]    scanned_row;
        logic [COL_IN_W-1:0] press_mask;
        logic [COL_IN_W-1:0] release_mask;
    } t_poll_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // predictor state
    logic [CNT_W-1:0]  lockout_ticks_cfg;
    logic [CNT_W-1:0]  lock_cnt [NUM_KEYS];
    logic              key_held [NUM_KEYS];
    logic [ROW_W-1:0]  drive_row;
    logic              in_read;
    logic [TIME_W-1:0] last_tick;

    t_poll_result pending_results[$];
    logic [TIME_W-1:0] tick_now;
    bit idle_en = 1'b1;
    int errors;
    int polls_sent;
    int reads_seen;
    int presses_seen;
    int releases_seen;
    int lockout_writes;
    int stall_cycles;

    key_matrix_scan_debounce #(
        .NUM_ROWS   (NUM_ROWS),
        .NUM_COLUMNS(NUM_COLUMNS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic void reset_scanner_model();
        lockout_ticks_cfg = LOCKOUT_RESET;
        for (int k = 0; k < NUM_KEYS; k++) begin
            lock_cnt[k] = '0;
            key_held[k] = 1'b0;
        end
        drive_row = ROW_W'(NUM_ROWS - 1);
        in_read   = 1'b0;
        last_tick = '0;
    endfunction

    function automatic t_poll_result predict_poll(input logic [TIME_W-1:0] tick,
                                                  input logic [COL_IN_W-1:0] cols);
        t_poll_result r;
        int key;
        r = '0;
        if (tick != last_tick) begin
            for (int k = 0; k < NUM_KEYS; k++)
                if (lock_cnt[k] != 0) lock_cnt[k] = lock_cnt[k] - 1'b1;
        end
        last_tick = tick;
        if (!in_read) begin
            drive_row = (drive_row >= ROW_W'(NUM_ROWS - 1)) ? '0 : drive_row + 1'b1;
            in_read = 1'b1;
        end else begin
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                key = drive_row * NUM_COLUMNS + c;
                if (lock_cnt[key] == 0) begin
                    if (cols[c] && !key_held[key]) begin
                        key_held[key] = 1'b1;
                        lock_cnt[key] = lockout_ticks_cfg;
                        r.press_mask[c] = 1'b1;
                    end else if (!cols[c] && key_held[key]) begin
                        key_held[key] = 1'b0;
                        lock_cnt[key] = lockout_ticks_cfg;
                        r.release_mask[c] = 1'b1;
                    end
                end
            end
            r.read_done   = 1'b1;
            r.scanned_row = drive_row;
            in_read = 1'b0;
        end
        r.row_drive = drive_row;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
                     act_v);
            errors++;
        end
    endtask

    // result checker and receiver backpressure
    always @(posedge i_clk) begin
        t_poll_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %0h/%0b", $time,
                         m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("row_drive", 16'(want.row_drive), 16'(m_axis_tdata[2:0]));
                check_field("read_done", 16'(want.read_done), 16'(m_axis_tuser));
                check_field("scanned_row", 16'(want.scanned_row), 16'(m_axis_tdata[5:3]));
                check_field("press_mask", 16'(want.press_mask), 16'(m_axis_tdata[10:6]));
                check_field("release_mask", 16'(want.release_mask),
                            16'(m_axis_tdata[15:11]));
                reads_seen    += want.read_done;
                presses_seen  += $countones(want.press_mask);
                releases_seen += $countones(want.release_mask);
            end
        end
        m_axis_tready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_poll(input logic [TIME_W-1:0] tick, input logic [COL_IN_W-1:0] cols);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, cols, tick};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_poll(tick, cols));
        polls_sent++;
        tick_now = tick;
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_lockout(input logic [CNT_W-1:0] ticks);
        wait_results_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        lockout_ticks_cfg = ticks;
        lockout_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_polls(input int count);
        logic [TIME_W-1:0] tick;
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            tick = tick_now;
            if (roll >= 45 && roll < 92) tick = tick_now + 1;
            else if (roll >= 92) tick = $urandom();
            send_poll(tick, COL_IN_W'($urandom_range(0, 31)));
            if ($urandom_range(0, 199) == 0) wait_results_drained();
        end
    endtask

    // first poll at tick zero skips the decrement; select results carry zero masks and scanned row
    task automatic test_reset_state();
        send_poll(32'h0, 5'h1F);
        send_poll(32'h0, 5'h1F);
        send_poll(32'hFFFF_FFFF, 5'h00);
        send_poll(32'hFFFF_FFFF, 5'h0A);
    endtask

    // a tick change on the read poll unlocks the key before it is compared
    task automatic test_decrement_order();
        set_lockout(16'd1);
        send_poll(32'd5, 5'h00);
        send_poll(32'd5, 5'h01);
        repeat (9) send_poll(32'd5, 5'h00);
        send_poll(32'd6, 5'h00);
    endtask

    task automatic test_zero_lockout();
        set_lockout(16'd0);
        send_poll(32'd6, 5'h00);
        send_poll(32'd6, 5'h1F);
        repeat (9) send_poll(32'd6, 5'h00);
        send_poll(32'd6, 5'h00);
    endtask

    task automatic test_random_default();
        set_lockout(LOCKOUT_RESET);
        run_random_polls(350);
    endtask

    task automatic test_random_no_idle();
        set_lockout(16'd1);
        idle_en = 1'b0;
        run_random_polls(250);
        wait_results_drained();
        idle_en = 1'b1;
    endtask

    task automatic test_random_lockout_sweep();
        set_lockout(16'd0);
        run_random_polls(250);
        set_lockout(16'd3);
        run_random_polls(250);
        set_lockout(CNT_W'($urandom_range(4, 60)));
        run_random_polls(250);
    endtask

    // keys pressed here stay locked for the rest of the run
    task automatic test_max_lockout();
        set_lockout(16'hFFFF);
        run_random_polls(150);
    endtask

    initial begin
        reset_scanner_model();
        tick_now = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_decrement_order();
        test_zero_lockout();
        test_random_default();
        test_random_no_idle();
        test_random_lockout_sweep();
        test_max_lockout();
        wait_results_drained();
        repeat (4) @(posedge i_clk);
        $display("Ran %0d polls (%0d reads) over %0d lockout settings, 0 to 65535.",
                 polls_sent, reads_seen, lockout_writes);
        $display("Saw %0d presses and %0d releases; %0d mismatches.", presses_seen,
                 releases_seen, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
